FILE: rtl/dpw_pkg.sv
`timescale 1ns / 1ps
package dpw_pkg;

    localparam int unsigned CNT_W  = 7;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned LIM_W  = 16;
    localparam int unsigned IDX_W  = 3;

    localparam logic [CNT_W-1:0] SKIP_EDGES      = 7'd3;
    localparam logic [CNT_W-1:0] DATA_LAST_EDGE  = 7'd67;
    localparam logic [CNT_W-1:0] FRAME_LAST_EDGE = 7'd83;
    localparam logic [CNT_W-1:0] COUNT_TOP       = 7'd127;

    localparam logic [LIM_W-1:0] ZERO_MIN_RST = 16'd1100;
    localparam logic [LIM_W-1:0] ZERO_MAX_RST = 16'd1500;
    localparam logic [LIM_W-1:0] ONE_MIN_RST  = 16'd3400;
    localparam logic [LIM_W-1:0] ONE_MAX_RST  = 16'd3750;

    localparam logic [1:0] REQ_EDGE  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef enum logic [IDX_W-1:0] {
        REG_ZERO_MIN = 3'd0,
        REG_ZERO_MAX = 3'd1,
        REG_ONE_MIN  = 3'd2,
        REG_ONE_MAX  = 3'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_EDGE  = 2'd1,
        OP_START = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] edge_time;
    } t_cmd;

endpackage

FILE: rtl/dpw_front.sv
`timescale 1ns / 1ps
module dpw_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              i_req_type,
    input  logic [dpw_pkg::TIME_W-1:0] i_edge_time,
    output logic                    o_cmd_valid,
    input  logic                    i_cmd_ready,
    output dpw_pkg::t_cmd           o_cmd
);
    import dpw_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;
    t_op  dec_op;

    assign full        = r_valid && !i_cmd_ready;
    assign accept      = push && !full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        case (i_req_type)
            REQ_EDGE:  dec_op = OP_EDGE;
            REQ_START: dec_op = OP_START;
            REQ_READ:  dec_op = OP_READ;
            default:   dec_op = OP_NONE;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (accept) begin
            n_valid         = 1'b1;
            n_cmd.op        = dec_op;
            n_cmd.edge_time = i_edge_time;
        end else if (r_valid && i_cmd_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

FILE: rtl/dpw_cmd_fifo.sv
`timescale 1ns / 1ps
module dpw_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  dpw_pkg::t_cmd i_wr_cmd,
    output logic          o_rd_valid,
    input  logic          i_rd_take,
    output dpw_pkg::t_cmd o_rd_cmd
);
    import dpw_pkg::*;

    t_cmd       r_mem [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       r_wr;
    logic       r_rd;
    logic       wr_en;
    logic       rd_en;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_cmd   = r_mem[r_rd];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = i_rd_take && o_rd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 2'd1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_en) begin
                r_wr <= ~r_wr;
            end
            if (rd_en) begin
                r_rd <= ~r_rd;
            end
        end
        if (wr_en) begin
            r_mem[r_wr] <= i_wr_cmd;
        end
    end

endmodule

FILE: rtl/dpw_back.sv
`timescale 1ns / 1ps
module dpw_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [dpw_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [dpw_pkg::LIM_W-1:0]  i_cfg_data,
    input  logic                       i_cmd_valid,
    output logic                       o_cmd_take,
    input  dpw_pkg::t_cmd              i_cmd,
    output logic                       empty,
    input  logic                       pop,
    output logic [dpw_pkg::TIME_W-1:0] o_raw_word,
    output logic                       o_data_ready
);
    import dpw_pkg::*;

    logic [LIM_W-1:0]  r_zero_min;
    logic [LIM_W-1:0]  r_zero_max;
    logic [LIM_W-1:0]  r_one_min;
    logic [LIM_W-1:0]  r_one_max;

    logic [CNT_W-1:0]  r_edge_count;
    logic [CNT_W-1:0]  n_edge_count;
    logic              r_rise_seen;
    logic              n_rise_seen;
    logic [TIME_W-1:0] r_rise_stamp;
    logic [TIME_W-1:0] n_rise_stamp;
    logic [TIME_W-1:0] r_shift_word;
    logic [TIME_W-1:0] n_shift_word;
    logic              r_ready_flag;
    logic              n_ready_flag;

    logic [TIME_W-1:0] r_q_word [2];
    logic              r_q_rdy  [2];
    logic [1:0]        r_q_cnt;
    logic [1:0]        n_q_cnt;
    logic              r_q_wr;
    logic              r_q_rd;
    logic              q_pop;

    logic [CNT_W-1:0]  cnt_inc;
    logic [TIME_W-1:0] width;
    logic              in_zero;
    logic              in_one;

    assign o_cmd_take   = i_cmd_valid && (r_q_cnt != 2'd2);
    assign empty        = (r_q_cnt == 2'd0);
    assign q_pop        = pop && !empty;
    assign o_raw_word   = r_q_word[r_q_rd];
    assign o_data_ready = r_q_rdy[r_q_rd];

    assign cnt_inc = (r_edge_count < COUNT_TOP) ? r_edge_count + 7'd1 : r_edge_count;
    assign width   = i_cmd.edge_time - r_rise_stamp;
    assign in_zero = (width >= {16'd0, r_zero_min}) && (width <= {16'd0, r_zero_max});
    assign in_one  = (width >= {16'd0, r_one_min}) && (width <= {16'd0, r_one_max});

    always_comb begin
        n_edge_count = r_edge_count;
        n_rise_seen  = r_rise_seen;
        n_rise_stamp = r_rise_stamp;
        n_shift_word = r_shift_word;
        n_ready_flag = r_ready_flag;
        case (i_cmd.op)
            OP_EDGE: begin
                n_edge_count = cnt_inc;
                if (cnt_inc <= SKIP_EDGES) begin
                    n_edge_count = cnt_inc;
                end else if (cnt_inc <= DATA_LAST_EDGE) begin
                    if (!r_rise_seen) begin
                        n_rise_stamp = i_cmd.edge_time;
                        n_rise_seen  = 1'b1;
                    end else begin
                        n_rise_seen = 1'b0;
                        if (in_zero) begin
                            n_shift_word = {r_shift_word[TIME_W-2:0], 1'b0};
                        end else if (in_one) begin
                            n_shift_word = {r_shift_word[TIME_W-2:0], 1'b1};
                        end
                    end
                end else if (cnt_inc == FRAME_LAST_EDGE) begin
                    n_ready_flag = 1'b1;
                end
            end
            OP_START: begin
                n_edge_count = '0;
                n_rise_seen  = 1'b0;
                n_ready_flag = 1'b0;
            end
            OP_READ: begin
                n_rise_seen  = 1'b0;
                n_ready_flag = 1'b0;
            end
            default: begin
                n_edge_count = r_edge_count;
            end
        endcase
    end

    always_comb begin
        n_q_cnt = r_q_cnt;
        if (o_cmd_take && !q_pop) begin
            n_q_cnt = r_q_cnt + 2'd1;
        end else if (q_pop && !o_cmd_take) begin
            n_q_cnt = r_q_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_min   <= ZERO_MIN_RST;
            r_zero_max   <= ZERO_MAX_RST;
            r_one_min    <= ONE_MIN_RST;
            r_one_max    <= ONE_MAX_RST;
            r_edge_count <= '0;
            r_rise_seen  <= 1'b0;
            r_rise_stamp <= '0;
            r_shift_word <= '0;
            r_ready_flag <= 1'b0;
            r_q_cnt      <= 2'd0;
            r_q_wr       <= 1'b0;
            r_q_rd       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ZERO_MIN: r_zero_min <= i_cfg_data;
                    REG_ZERO_MAX: r_zero_max <= i_cfg_data;
                    REG_ONE_MIN:  r_one_min  <= i_cfg_data;
                    REG_ONE_MAX:  r_one_max  <= i_cfg_data;
                    default:      r_one_max  <= r_one_max;
                endcase
            end
            if (o_cmd_take) begin
                r_edge_count <= n_edge_count;
                r_rise_seen  <= n_rise_seen;
                r_rise_stamp <= n_rise_stamp;
                r_shift_word <= n_shift_word;
                r_ready_flag <= n_ready_flag;
                r_q_wr       <= ~r_q_wr;
            end
            if (q_pop) begin
                r_q_rd <= ~r_q_rd;
            end
            r_q_cnt <= n_q_cnt;
        end
        if (o_cmd_take) begin
            r_q_word[r_q_wr] <= n_shift_word;
            r_q_rdy[r_q_wr]  <= n_ready_flag;
        end
    end

endmodule

FILE: rtl/dht_pulse_width_bit_decoder.sv
`timescale 1ns / 1ps
// Pulse-width bit decoder for a single-wire humidity/temperature sensor.
// Input queue: drive req_type and edge_time with push; a beat is taken at a
// clock edge with push high and full low. Request 0 is a captured edge, 1
// starts a new reading, 2 reads the raw word and clears data_ready.
// Result queue: one result per request. While empty is low the oldest result
// (raw_word, data_ready) is on the outputs; pop high takes it.
// Config: write zero/one pulse-width window limits (index 0..3) with
// i_cfg_valid; o_cfg_ready is always high. Write only while the block is idle.
// Datapath: a taken request passes the input register, the two-entry command
// queue and the execute stage into the result queue.
// Throughput: one request per cycle while the result queue has room, set by
// the execute stage that subtracts the rise stamp and compares against both windows.
// Reset: counters, flags, stamp and word clear, limits return to defaults,
// both queues empty. No clearing pass.
// Receiver stall: the two-entry result queue fills, then the command queue,
// then full rises; nothing is dropped.
module dht_pulse_width_bit_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 i_req_type,
    input  logic [dpw_pkg::TIME_W-1:0] i_edge_time,
    output logic                       empty,
    input  logic                       pop,
    output logic [dpw_pkg::TIME_W-1:0] o_raw_word,
    output logic                       o_data_ready,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dpw_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [dpw_pkg::LIM_W-1:0]  i_cfg_data
);
    import dpw_pkg::*;

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_take;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    dpw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req_type  (i_req_type),
        .i_edge_time (i_edge_time),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    dpw_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_cmd   (f_cmd),
        .o_rd_valid (q_valid),
        .i_rd_take  (q_take),
        .o_rd_cmd   (q_cmd)
    );

    dpw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_valid  (q_valid),
        .o_cmd_take   (q_take),
        .i_cmd        (q_cmd),
        .empty        (empty),
        .pop          (pop),
        .o_raw_word   (o_raw_word),
        .o_data_ready (o_data_ready)
    );

endmodule

FILE: verif/tb_dht_pulse_width_bit_decoder.sv
`timescale 1ns / 1ps
module tb_dht_pulse_width_bit_decoder;
    import dpw_pkg::*;

    localparam logic [1:0]       REQ_UNKNOWN   = 2'd3;
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int               CYCLE_LIMIT   = 200000;
    localparam int               HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [TIME_W-1:0] word;
        logic              ready;
    } t_reading;

    typedef struct packed {
        logic [1:0]        req;
        logic [TIME_W-1:0] stamp;
        logic              fixed;
        logic [TIME_W-1:0] word;
        logic              ready;
    } t_directed_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              push        = 1'b0;
    logic              full;
    logic [1:0]        i_req_type  = REQ_EDGE;
    logic [TIME_W-1:0] i_edge_time = '0;
    logic              empty;
    logic              pop         = 1'b0;
    logic [TIME_W-1:0] o_raw_word;
    logic              o_data_ready;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [LIM_W-1:0]  i_cfg_data  = '0;

    logic [LIM_W-1:0]  lim_zero_min = ZERO_MIN_RST;
    logic [LIM_W-1:0]  lim_zero_max = ZERO_MAX_RST;
    logic [LIM_W-1:0]  lim_one_min  = ONE_MIN_RST;
    logic [LIM_W-1:0]  lim_one_max  = ONE_MAX_RST;
    logic [CNT_W-1:0]  edge_total   = '0;
    logic              rise_pending = 1'b0;
    logic [TIME_W-1:0] rise_time    = '0;
    logic [TIME_W-1:0] data_word    = '0;
    logic              frame_done   = 1'b0;

    t_reading pending_readings[$];
    int       beats_sent       = 0;
    int       readings_checked = 0;
    int       frames_flagged   = 0;
    int       mismatches       = 0;
    int       cycle_count      = 0;
    int       hold_left        = 0;
    bit       gaps_on          = 1'b1;

    t_directed_row directed_rows [24] = '{
        '{REQ_READ,    32'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{REQ_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
        '{REQ_START,   32'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{REQ_EDGE,    32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
        '{REQ_EDGE,    32'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{REQ_EDGE,    32'h0000_3039, 1'b1, 32'h0, 1'b0},
        '{REQ_EDGE,    32'hFFFF_FF00, 1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'h0000_0350, 1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd0,         1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd3400,      1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd1499,      1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd100,       1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd3850,      1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd0,         1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd2000,      1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd0,         1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd1099,      1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd7,         1'b0, 32'h0, 1'b0},
        '{REQ_READ,    32'h5A5A_A5A5, 1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd10,        1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd3761,      1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd0,         1'b0, 32'h0, 1'b0},
        '{REQ_EDGE,    32'd3399,      1'b0, 32'h0, 1'b0}
    };

    dht_pulse_width_bit_decoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_edge_time  (i_edge_time),
        .empty        (empty),
        .pop          (pop),
        .o_raw_word   (o_raw_word),
        .o_data_ready (o_data_ready),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_reading decode_request(input logic [1:0] req,
                                                input logic [TIME_W-1:0] stamp_in);
        logic [TIME_W-1:0] width;
        case (req)
            REQ_EDGE: begin
                if (edge_total != COUNT_TOP) edge_total = edge_total + 1'b1;
                if (edge_total > SKIP_EDGES && edge_total <= DATA_LAST_EDGE) begin
                    if (!rise_pending) begin
                        rise_time    = stamp_in;
                        rise_pending = 1'b1;
                    end else begin
                        width        = stamp_in - rise_time;
                        rise_pending = 1'b0;
                        if (width >= lim_zero_min && width <= lim_zero_max)
                            data_word = {data_word[TIME_W-2:0], 1'b0};
                        else if (width >= lim_one_min && width <= lim_one_max)
                            data_word = {data_word[TIME_W-2:0], 1'b1};
                    end
                end else if (edge_total == FRAME_LAST_EDGE) begin
                    frame_done = 1'b1;
                end
            end
            REQ_START: begin
                edge_total   = '0;
                rise_pending = 1'b0;
                frame_done   = 1'b0;
            end
            REQ_READ: begin
                frame_done   = 1'b0;
                rise_pending = 1'b0;
            end
            default: ;
        endcase
        return '{data_word, frame_done};
    endfunction

    function automatic logic [TIME_W-1:0] pick_width();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4 && lim_zero_min <= lim_zero_max)
            return $urandom_range(lim_zero_max, lim_zero_min);
        if (sel < 7 && lim_one_min <= lim_one_max)
            return $urandom_range(lim_one_max, lim_one_min);
        if (sel == 7) begin
            case ($urandom_range(5))
                0:       return {16'h0, lim_zero_min} - 1;
                1:       return {16'h0, lim_zero_max} + 1;
                2:       return {16'h0, lim_one_min} - 1;
                3:       return {16'h0, lim_one_max} + 1;
                4:       return {16'h0, lim_zero_min};
                default: return {16'h0, lim_one_max};
            endcase
        end
        if (sel == 8) return $urandom_range(65535);
        return $urandom();
    endfunction

    task automatic send_request(input logic [1:0] req, input logic [TIME_W-1:0] stamp_in,
                                input logic fixed = 1'b0, input t_reading typed = '0);
        t_reading predicted;
        while (gaps_on && $urandom_range(99) < 37) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_req_type  <= req;
        i_edge_time <= stamp_in;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predicted = decode_request(req, stamp_in);
        pending_readings.push_back(fixed ? typed : predicted);
        beats_sent++;
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_windows(input logic [LIM_W-1:0] zmin, input logic [LIM_W-1:0] zmax,
                                   input logic [LIM_W-1:0] omin, input logic [LIM_W-1:0] omax,
                                   input bit with_spare);
        logic [IDX_W-1:0] idx [5];
        logic [LIM_W-1:0] val [5];
        int               k;
        idx = '{REG_ZERO_MIN, REG_ZERO_MAX, REG_ONE_MIN, REG_ONE_MAX, CFG_IDX_SPARE};
        val = '{zmin, zmax, omin, omax, LIM_W'($urandom())};
        for (k = 0; k < (with_spare ? 5 : 4); k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[k])
                REG_ZERO_MIN: lim_zero_min = val[k];
                REG_ZERO_MAX: lim_zero_max = val[k];
                REG_ONE_MIN:  lim_one_min  = val[k];
                REG_ONE_MAX:  lim_one_max  = val[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input int extra_edges);
        logic [TIME_W-1:0] stamp;
        int                n;
        int                noise;
        stamp = $urandom();
        if ($urandom_range(9) != 0) send_request(REQ_START, $urandom());
        for (n = 1; n <= FRAME_LAST_EDGE + extra_edges; n++) begin
            noise = $urandom_range(199);
            if (noise < 3) send_request(REQ_READ, $urandom());
            else if (noise < 5) send_request(REQ_UNKNOWN, $urandom());
            else if (noise < 6) send_request(REQ_START, $urandom());
            else if (noise < 9) send_request(REQ_EDGE, $urandom());
            if (n > SKIP_EDGES && n <= DATA_LAST_EDGE && n % 2 == 1)
                stamp = stamp + pick_width();
            else
                stamp = stamp + $urandom_range(6000, 1);
            send_request(REQ_EDGE, stamp);
        end
        if ($urandom_range(4) != 0) send_request(REQ_READ, $urandom());
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_dht_pulse_width_bit_decoder NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_readings.size() == 0) begin
                    $error("result beat with nothing expected: raw_word %h data_ready %b",
                           o_raw_word, o_data_ready);
                    mismatches++;
                end else begin
                    want = pending_readings.pop_front();
                    if (o_raw_word !== want.word) begin
                        $error("raw_word expected %h actual %h", want.word, o_raw_word);
                        mismatches++;
                    end
                    if (o_data_ready !== want.ready) begin
                        $error("data_ready expected %b actual %b", want.ready, o_data_ready);
                        mismatches++;
                    end
                    if (want.ready) frames_flagged++;
                end
                readings_checked++;
                if (readings_checked == 250 || readings_checked == 550)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (gaps_on) begin
                pop <= ($urandom_range(99) >= 37);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int phase;
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < 24; k++)
            send_request(directed_rows[k].req, directed_rows[k].stamp, directed_rows[k].fixed,
                         '{directed_rows[k].word, directed_rows[k].ready});

        for (phase = 0; phase < 6; phase++) begin
            settle();
            repeat (4) @(posedge i_clk);
            case (phase)
                1: program_windows(16'd1000, 16'd4000, 16'd3000, 16'd5000, 1'b0);
                2: program_windows(16'd2000, 16'd1000, 16'd100, 16'd200, 1'b1);
                3: program_windows(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
                4: program_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
                5: program_windows(LIM_W'($urandom_range(3000)), LIM_W'($urandom_range(4000, 3000)),
                                   LIM_W'($urandom_range(8000, 4100)),
                                   LIM_W'($urandom_range(12000, 8000)), 1'b1);
                default: ;
            endcase
            gaps_on = (phase != 4);
            repeat ((phase == 0 || phase == 5) ? 2 : 1)
                send_frame(phase == 1 ? 48 : 0);
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("%0d request beats, %0d results checked, %0d with data_ready set",
                 beats_sent, readings_checked, frames_flagged);
        $display("window settings: reset, overlapping, empty zero window, extremes, full range, random");
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("tb_dht_pulse_width_bit_decoder OK");
        end else begin
            $display("tb_dht_pulse_width_bit_decoder NOT OK");
        end
        $finish;
    end

endmodule
